[rtl/assert_macros.svh]
// Assertion macros used by the RTL top file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked out of reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked out of reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

[rtl/gfcs_pkg.sv]
package gfcs_pkg;

  localparam int CELL_W      = 16;
  localparam int DIM_W       = 9;
  localparam int COL_W       = 8;
  localparam int REACH_W     = 5;
  localparam int CFG_IDX_W   = 1;
  localparam int MAX_REACH   = 16;
  localparam int MAX_COLUMNS = 256;
  localparam int MAX_ROWS    = 256;
  localparam int DIV_STEPS   = CELL_W;
  localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_COLUMNS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS    = 1'b1;

  localparam logic [DIM_W-1:0] DIM_RESET = 9'd16;

  typedef enum logic [1:0] {
    DIR_LEFT  = 2'd0,
    DIR_UP    = 2'd1,
    DIR_RIGHT = 2'd2,
    DIR_DOWN  = 2'd3
  } dir_e;

  // One result request toward the output register
  typedef struct packed {
    logic [CELL_W-1:0] found_cell;
    logic              empty_scope;
    logic              last_of_run;
  } res_t;

  // Map a raw grid dimension onto 1..max
  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v,
                                              input logic [DIM_W-1:0] maxv);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > maxv) begin
      r = maxv;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

[rtl/gfcs_divider.sv]
module gfcs_divider (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [gfcs_pkg::CELL_W-1:0] dividend_i,
  input  logic [gfcs_pkg::DIM_W-1:0]  divisor_i,
  output logic                        done_o,
  output logic [gfcs_pkg::CELL_W-1:0] quotient_o,
  output logic [gfcs_pkg::COL_W-1:0]  remainder_o
);
  import gfcs_pkg::*;

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [CELL_W-1:0]    quo_q, quo_d;
  logic [DIM_W-1:0]     div_q, div_d;
  logic [DIM_W-1:0]     rem_q, rem_d;

  logic [DIM_W:0]       trial;
  logic [DIM_W+1:0]     diff;
  logic                 fits;

  // One restoring step per cycle: shift in a dividend bit, try the subtract
  always_comb begin
    trial = {rem_q, quo_q[CELL_W-1]};
    diff  = {1'b0, trial} - {2'b00, div_q};
    fits  = ~diff[DIM_W+1];
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    div_d  = div_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quo_d  = dividend_i;
      div_d  = divisor_i;
      rem_d  = '0;
    end else if (busy_q) begin
      quo_d = {quo_q[CELL_W-2:0], fits};
      rem_d = fits ? diff[DIM_W-1:0] : trial[DIM_W-1:0];
      cnt_d = cnt_q + DIV_CNT_W'(1);
      if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    div_q <= div_d;
    rem_q <= rem_d;
  end

  // Remainder stays below the divisor, so its top bit is always clear
  assign done_o      = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q[COL_W-1:0];

endmodule

[rtl/gfcs_out_reg.sv]
module gfcs_out_reg (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push_valid_i,
  input  gfcs_pkg::res_t              push_data_i,
  output logic                        push_ready_o,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [gfcs_pkg::CELL_W-1:0] m_axis_tdata,
  output logic                        m_axis_tuser,
  output logic                        m_axis_tlast
);
  import gfcs_pkg::*;

  logic valid_q, valid_d;
  res_t data_q, data_d;

  // Take a new request whenever the held one leaves or none is held
  assign push_ready_o = ~valid_q | m_axis_tready;

  always_comb begin
    valid_d = valid_q;
    data_d  = data_q;
    if (push_ready_o) begin
      valid_d = push_valid_i;
      data_d  = push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = data_q.found_cell;
  assign m_axis_tuser  = data_q.empty_scope;
  assign m_axis_tlast  = data_q.last_of_run;

endmodule

[rtl/grid_front_cell_scan.sv]
// Channel   | Direction | Payload
// s_axis    | in        | tdata[15:0] cell_index, [17:16] heading, [22:18] reach
// m_axis    | out       | tdata found_cell, tuser empty_scope, tlast last_of_run
// cfg       | in        | cfg_idx_i 0 grid_columns, 1 grid_rows; cfg_data_i value
//
// A request passes a serial divide by the column count, then for each origin a step
// to place it and a step to clamp its run, a run start step for each origin with a
// run, an emit step for each cell found, the final result and a return to idle.
// s_axis_tready is high only while idle.
// A stalled m_axis holds the sequencer until the final result is in the output register.
// rst_ni clears control state and sets both grid dimensions to 16.
module grid_front_cell_scan (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [23:0]                      s_axis_tdata, // cell_index, heading, reach
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [gfcs_pkg::CELL_W-1:0]      m_axis_tdata, // found_cell
  output logic                             m_axis_tuser, // empty_scope
  output logic                             m_axis_tlast,
  input  logic                             cfg_we_i,
  input  logic [gfcs_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [gfcs_pkg::DIM_W-1:0]       cfg_data_i
);
  import gfcs_pkg::*;
`include "assert_macros.svh"

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_ORG,
    ST_LIM,
    ST_START,
    ST_EMIT,
    ST_FIN
  } state_e;

  localparam logic [DIM_W-1:0] MAX_C = DIM_W'(MAX_COLUMNS);
  localparam logic [DIM_W-1:0] MAX_R = DIM_W'(MAX_ROWS);

  // Configuration registers
  logic [DIM_W-1:0] cfg_cols_q, cfg_rows_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_cols_q <= DIM_RESET;
      cfg_rows_q <= DIM_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_COLUMNS: cfg_cols_q <= cfg_data_i;
        REG_ROWS:    cfg_rows_q <= cfg_data_i;
        default:     ;
      endcase
    end
  end

  // Input unpacking
  logic [CELL_W-1:0]  in_cell;
  logic [1:0]         in_head;
  logic [REACH_W-1:0] in_reach;
  logic [DIM_W-1:0]   in_cols;
  logic               in_accept;

  assign in_cell   = s_axis_tdata[CELL_W-1:0];
  assign in_head   = s_axis_tdata[CELL_W+1:CELL_W];
  assign in_reach  = s_axis_tdata[CELL_W+2+REACH_W-1:CELL_W+2];
  assign in_cols   = eff_dim(cfg_cols_q, MAX_C);
  assign in_accept = s_axis_tvalid & s_axis_tready;

  // Divider gives row and column of the request cell
  logic              div_done;
  logic [CELL_W-1:0] div_quo;
  logic [COL_W-1:0]  div_rem;

  gfcs_divider u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (in_accept),
    .dividend_i  (in_cell),
    .divisor_i   (in_cols),
    .done_o      (div_done),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  // Sequencer state
  state_e             state_q, state_d;
  logic [CELL_W-1:0]  cur_q, cur_d;
  dir_e               head_q, head_d;
  logic [REACH_W-1:0] step_q, step_d;
  logic [DIM_W-1:0]   c_q, c_d, r_q, r_d;
  logic [CELL_W-1:0]  row_q, row_d;
  logic [COL_W-1:0]   col_q, col_d;
  logic [1:0]         org_q, org_d;
  logic [CELL_W-1:0]  ocell_q, ocell_d;
  logic [COL_W-1:0]   orow_q, orow_d, ocol_q, ocol_d;
  logic               ook_q, ook_d;
  logic [REACH_W-1:0] n_q, n_d;
  logic [CELL_W-1:0]  pos_q, pos_d;
  logic [REACH_W-1:0] cnt_q, cnt_d;
  logic               hold_v_q, hold_v_d;
  logic [CELL_W-1:0]  hold_cell_q, hold_cell_d;

  logic               push_valid, push_ready;
  res_t               push_data;

  // Origin derivation
  dir_e               side;
  logic               row_in;
  logic [CELL_W-1:0]  row_up;
  logic [CELL_W:0]    row_dn;
  logic [DIM_W-1:0]   col_nx;
  logic               org_ok;
  logic [CELL_W-1:0]  org_cell, org_row;
  logic [COL_W-1:0]   org_col;

  always_comb begin
    side   = (org_q == 2'd0) ? dir_e'(2'(head_q + 2'd3)) : dir_e'(2'(head_q + 2'd1));
    row_in = row_q < {{(CELL_W-DIM_W){1'b0}}, r_q};
    row_up = row_q - CELL_W'(1);
    row_dn = {1'b0, row_q} + (CELL_W+1)'(1);
    col_nx = {1'b0, col_q} + DIM_W'(1);
    org_ok   = row_in;
    org_cell = cur_q;
    org_row  = row_q;
    org_col  = col_q;
    if (org_q != 2'd2) begin
      unique case (side)
        DIR_LEFT: begin
          org_ok   = row_in && (col_q != '0);
          org_cell = cur_q - CELL_W'(1);
          org_col  = col_q - COL_W'(1);
        end
        DIR_UP: begin
          org_ok   = (row_q != '0) && (row_up < {{(CELL_W-DIM_W){1'b0}}, r_q});
          org_cell = cur_q - {{(CELL_W-DIM_W){1'b0}}, c_q};
          org_row  = row_up;
        end
        DIR_RIGHT: begin
          org_ok   = row_in && (col_nx != c_q);
          org_cell = cur_q + CELL_W'(1);
          org_col  = col_nx[COL_W-1:0];
        end
        DIR_DOWN: begin
          org_ok   = row_dn < {{(CELL_W+1-DIM_W){1'b0}}, r_q};
          org_cell = cur_q + {{(CELL_W-DIM_W){1'b0}}, c_q};
          org_row  = row_dn[CELL_W-1:0];
        end
        default: ;
      endcase
    end
  end

  // Run length, clamped at the grid edge
  logic [DIM_W-1:0]   lim;
  logic [REACH_W-1:0] run_n;

  always_comb begin
    unique case (head_q)
      DIR_LEFT:  lim = {1'b0, ocol_q};
      DIR_UP:    lim = {1'b0, orow_q};
      DIR_RIGHT: lim = c_q - DIM_W'(1) - {1'b0, ocol_q};
      DIR_DOWN:  lim = r_q - DIM_W'(1) - {1'b0, orow_q};
      default:   lim = '0;
    endcase
    run_n = ({{(DIM_W-REACH_W){1'b0}}, step_q} > lim) ? lim[REACH_W-1:0] : step_q;
  end

  // Run start and stride
  logic [DIM_W-1:0]         stride;
  logic [REACH_W+DIM_W-1:0] span;
  logic [CELL_W-1:0]        run_start;

  always_comb begin
    stride = head_q[0] ? c_q : DIM_W'(1);
    span   = {{DIM_W{1'b0}}, n_q} * {{REACH_W{1'b0}}, stride};
    if (head_q == DIR_RIGHT || head_q == DIR_DOWN) begin
      run_start = ocell_q + {{(CELL_W-DIM_W){1'b0}}, stride};
    end else begin
      run_start = ocell_q - {{(CELL_W-REACH_W-DIM_W){1'b0}}, span};
    end
  end

  // Sequencer next state
  always_comb begin
    state_d     = state_q;
    cur_d       = cur_q;
    head_d      = head_q;
    step_d      = step_q;
    c_d         = c_q;
    r_d         = r_q;
    row_d       = row_q;
    col_d       = col_q;
    org_d       = org_q;
    ocell_d     = ocell_q;
    orow_d      = orow_q;
    ocol_d      = ocol_q;
    ook_d       = ook_q;
    n_d         = n_q;
    pos_d       = pos_q;
    cnt_d       = cnt_q;
    hold_v_d    = hold_v_q;
    hold_cell_d = hold_cell_q;
    push_valid  = 1'b0;
    push_data   = '{found_cell: hold_cell_q, empty_scope: 1'b0, last_of_run: 1'b0};

    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          cur_d    = in_cell;
          head_d   = dir_e'(in_head);
          step_d   = (in_reach > REACH_W'(MAX_REACH)) ? REACH_W'(MAX_REACH) : in_reach;
          c_d      = in_cols;
          r_d      = eff_dim(cfg_rows_q, MAX_R);
          org_d    = '0;
          hold_v_d = 1'b0;
          state_d  = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          row_d   = div_quo;
          col_d   = div_rem;
          state_d = ST_ORG;
        end
      end
      ST_ORG: begin
        ook_d   = org_ok;
        ocell_d = org_cell;
        orow_d  = org_row[COL_W-1:0];
        ocol_d  = org_col;
        state_d = ST_LIM;
      end
      ST_LIM: begin
        n_d = run_n;
        if (!ook_q || run_n == '0) begin
          org_d   = org_q + 2'd1;
          state_d = (org_q == 2'd2) ? ST_FIN : ST_ORG;
        end else begin
          state_d = ST_START;
        end
      end
      ST_START: begin
        pos_d   = run_start;
        cnt_d   = n_q;
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        // Hold one result back so the final one can carry the last flag
        push_valid = hold_v_q;
        if (!hold_v_q || push_ready) begin
          hold_v_d    = 1'b1;
          hold_cell_d = pos_q;
          pos_d       = pos_q + {{(CELL_W-DIM_W){1'b0}}, stride};
          cnt_d       = cnt_q - REACH_W'(1);
          if (cnt_q == REACH_W'(1)) begin
            org_d   = org_q + 2'd1;
            state_d = (org_q == 2'd2) ? ST_FIN : ST_ORG;
          end
        end
      end
      ST_FIN: begin
        push_valid = 1'b1;
        if (hold_v_q) begin
          push_data = '{found_cell: hold_cell_q, empty_scope: 1'b0, last_of_run: 1'b1};
        end else begin
          push_data = '{found_cell: '0, empty_scope: 1'b1, last_of_run: 1'b1};
        end
        if (push_ready) begin
          hold_v_d = 1'b0;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      hold_v_q <= 1'b0;
      org_q    <= '0;
      cnt_q    <= '0;
    end else begin
      state_q  <= state_d;
      hold_v_q <= hold_v_d;
      org_q    <= org_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q       <= cur_d;
    head_q      <= head_d;
    step_q      <= step_d;
    c_q         <= c_d;
    r_q         <= r_d;
    row_q       <= row_d;
    col_q       <= col_d;
    ocell_q     <= ocell_d;
    orow_q      <= orow_d;
    ocol_q      <= ocol_d;
    ook_q       <= ook_d;
    n_q         <= n_d;
    pos_q       <= pos_d;
    hold_cell_q <= hold_cell_d;
  end

  assign s_axis_tready = (state_q == ST_IDLE);

  gfcs_out_reg u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_valid_i  (push_valid),
    .push_data_i   (push_data),
    .push_ready_o  (push_ready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // Checks
  `ASSERT_IMPLIES(a_idle_nothing_held, clk_i, rst_ni, s_axis_tready, !hold_v_q)
  `ASSERT_IMPLIES(a_empty_is_last, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser, m_axis_tlast)
  `ASSERT_IMPLIES(a_empty_zero_cell, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser, m_axis_tdata == '0)
  `ASSERT_IMPLIES(a_div_done_in_div, clk_i, rst_ni, div_done, state_q == ST_DIV)
  `ASSERT_NEXT(a_accept_starts_div, clk_i, rst_ni, in_accept, state_q == ST_DIV)

endmodule

[tb/sv/tb_grid_front_cell_scan.sv]
module tb_grid_front_cell_scan;
  import gfcs_pkg::*;

  localparam int IDLE_LIMIT  = 3000;

  // One scan request waiting in the sender's queue
  typedef struct {
    logic [CELL_W-1:0]  cell_idx;
    dir_e               heading;
    logic [REACH_W-1:0] reach;
    bit                 drain;
  } scan_req_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [23:0]          s_axis_tdata = '0;  // cell_index, heading, reach
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [CELL_W-1:0]    m_axis_tdata;       // found_cell
  logic                 m_axis_tuser;       // empty_scope
  logic                 m_axis_tlast;       // last_of_run
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [DIM_W-1:0]     cfg_data_i = '0;

  // Shadow copy of the grid registers
  logic [DIM_W-1:0] grid_cols = DIM_RESET;
  logic [DIM_W-1:0] grid_rows = DIM_RESET;

  scan_req_t scan_q[$];
  res_t      cell_exp_q[$];
  scan_req_t src_req = '{cell_idx: '0, heading: DIR_LEFT, reach: '0, drain: 1'b0};
  bit        src_busy = 1'b0;
  int        src_wait = 0;
  int        snk_wait = 0;
  bit        src_nogap = 1'b0;
  bit        snk_nogap = 1'b0;
  res_t      want_res;
  int        err_cnt = 0;
  int        scans_sent = 0;
  int        results_seen = 0;
  int        empties_seen = 0;
  int        settings_cnt = 0;
  int        idle_cycles = 0;

  grid_front_cell_scan dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Map a register value onto the size the grid really has
  function automatic int grid_size(logic [DIM_W-1:0] v, int maxv);
    if (v == '0) return 1;
    return (int'(v) > maxv) ? maxv : int'(v);
  endfunction

  // Side neighbor of a cell, -1 when it falls off the grid
  function automatic int side_cell(int cur, dir_e d, int c, int total);
    int n;
    n = -1;
    case (d)
      DIR_LEFT:  if (cur % c != 0) n = cur - 1;
      DIR_UP:    n = cur - c;
      DIR_RIGHT: if (cur % c != c - 1) n = cur + 1;
      default:   n = cur + c;
    endcase
    if (n < 0 || n >= total) n = -1;
    return n;
  endfunction

  // Work out the cells ahead of the three origins and queue them as expectations
  function automatic void predict_scan(scan_req_t rq);
    int         c, r, total, cur, steps, o, row, col, lim;
    int         origin[3];
    logic [1:0] hd_l, hd_r;
    res_t       run_q[$];
    c     = grid_size(grid_cols, MAX_COLUMNS);
    r     = grid_size(grid_rows, MAX_ROWS);
    total = c * r;
    cur   = int'(rq.cell_idx);
    steps = (int'(rq.reach) > MAX_REACH) ? MAX_REACH : int'(rq.reach);
    hd_l  = rq.heading + 2'd3;
    hd_r  = rq.heading + 2'd1;
    origin[0] = side_cell(cur, dir_e'(hd_l), c, total);
    origin[1] = side_cell(cur, dir_e'(hd_r), c, total);
    origin[2] = (cur < total) ? cur : -1;
    foreach (origin[k]) begin
      if (origin[k] >= 0) begin
        o   = origin[k];
        row = o / c;
        col = o % c;
        // left and up runs list the farthest cell first
        case (rq.heading)
          DIR_LEFT: begin
            lim = (steps < col) ? steps : col;
            for (int i = lim; i >= 1; i--) begin
              run_q.insert(run_q.size(), {CELL_W'(o - i), 2'b00});
            end
          end
          DIR_UP: begin
            lim = (steps < row) ? steps : row;
            for (int i = lim; i >= 1; i--) begin
              run_q.insert(run_q.size(), {CELL_W'(o - i * c), 2'b00});
            end
          end
          DIR_RIGHT: begin
            lim = (steps < c - col - 1) ? steps : c - col - 1;
            for (int i = 1; i <= lim; i++) begin
              run_q.insert(run_q.size(), {CELL_W'(o + i), 2'b00});
            end
          end
          default: begin
            lim = (steps < r - row - 1) ? steps : r - row - 1;
            for (int i = 1; i <= lim; i++) begin
              run_q.insert(run_q.size(), {CELL_W'(o + i * c), 2'b00});
            end
          end
        endcase
      end
    end
    if (run_q.size() == 0) run_q.insert(0, {CELL_W'(0), 1'b1, 1'b0});
    run_q[run_q.size() - 1].last_of_run = 1'b1;
    foreach (run_q[k]) cell_exp_q.insert(cell_exp_q.size(), run_q[k]);
  endfunction

  task automatic flag_mismatch(input string what, input int unsigned want,
                               input int unsigned got);
    $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
    err_cnt++;
  endtask

  // Sender: hold each request until accepted, then wait out a random gap
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      src_busy = 1'b0;
      src_wait = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_scan(src_req);
        scans_sent++;
        src_busy = 1'b0;
        src_wait = src_nogap ? 0 : $urandom_range(0, 6);
      end
      if (!src_busy) begin
        if (src_wait > 0) begin
          src_wait--;
        end else if (scan_q.size() != 0 && (!scan_q[0].drain || cell_exp_q.size() == 0)) begin
          src_req  = scan_q.pop_front();
          src_busy = 1'b1;
        end
      end
      s_axis_tvalid <= src_busy;
      s_axis_tdata  <= {1'b0, src_req.reach, src_req.heading, src_req.cell_idx};
    end
  end

  // Receiver: check each result against the oldest expectation, stall at random
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      snk_wait = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        results_seen++;
        if (m_axis_tuser) empties_seen++;
        if (cell_exp_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, got cell %0d empty %0b last %0b",
                   $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
          err_cnt++;
        end else begin
          want_res = cell_exp_q.pop_front();
          if (m_axis_tdata !== want_res.found_cell)
            flag_mismatch("found_cell", want_res.found_cell, m_axis_tdata);
          if (m_axis_tuser !== want_res.empty_scope)
            flag_mismatch("empty_scope", want_res.empty_scope, m_axis_tuser);
          if (m_axis_tlast !== want_res.last_of_run)
            flag_mismatch("last_of_run", want_res.last_of_run, m_axis_tlast);
        end
        snk_wait = snk_nogap ? 0 : $urandom_range(0, 6);
      end else if (!m_axis_tvalid && !snk_nogap && snk_wait == 0 && $urandom_range(0, 7) == 0) begin
        snk_wait = $urandom_range(0, 6);
      end
      if (snk_wait > 0) begin
        snk_wait--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic void queue_scan(logic [CELL_W-1:0] idx, dir_e hd,
                                     logic [REACH_W-1:0] rch, bit drain);
    scan_req_t rq;
    rq = '{cell_idx: idx, heading: hd, reach: rch, drain: drain};
    scan_q.insert(scan_q.size(), rq);
  endfunction

  // Write both grid dimensions; only called while the block is idle
  task automatic set_grid(input logic [DIM_W-1:0] cols, input logic [DIM_W-1:0] rows);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= REG_COLUMNS;
    cfg_data_i <= cols;
    @(posedge clk_i);
    cfg_idx_i  <= REG_ROWS;
    cfg_data_i <= rows;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    grid_cols = cols;
    grid_rows = rows;
    settings_cnt++;
  endtask

  // Random requests, weighted toward cells inside the grid and its borders
  task automatic add_random(input int n);
    int                c, r, total;
    logic [CELL_W-1:0] idx;
    logic [REACH_W-1:0] rch;
    c     = grid_size(grid_cols, MAX_COLUMNS);
    r     = grid_size(grid_rows, MAX_ROWS);
    total = c * r;
    repeat (n) begin
      case ($urandom_range(0, 9))
        0: idx = CELL_W'($urandom);
        1: idx = CELL_W'(total + $urandom_range(0, c));
        2: idx = CELL_W'(($urandom_range(0, 1) ? (r - 1) * c : 0) + $urandom_range(0, c - 1));
        3: idx = CELL_W'($urandom_range(0, r - 1) * c + ($urandom_range(0, 1) ? c - 1 : 0));
        default: idx = CELL_W'($urandom_range(0, total - 1));
      endcase
      if ($urandom_range(0, 7) == 0) rch = REACH_W'($urandom_range(17, 31));
      else rch = REACH_W'($urandom_range(0, 16));
      queue_scan(idx, dir_e'($urandom_range(0, 3)), rch, $urandom_range(0, 19) == 0);
    end
  endtask

  task automatic wait_idle();
    do @(posedge clk_i);
    while (scan_q.size() != 0 || src_busy || cell_exp_q.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset geometry 16x16: corners, zero and long reach, cells past the grid
    queue_scan(16'd0, DIR_LEFT, 5'd0, 1'b0);
    queue_scan(16'd0, DIR_UP, 5'd16, 1'b1);
    queue_scan(16'd0, DIR_RIGHT, 5'd16, 1'b0);
    queue_scan(16'd0, DIR_DOWN, 5'd16, 1'b0);
    queue_scan(16'd255, DIR_LEFT, 5'd16, 1'b0);
    queue_scan(16'd255, DIR_UP, 5'd31, 1'b0);
    queue_scan(16'd255, DIR_RIGHT, 5'd5, 1'b0);
    queue_scan(16'd255, DIR_DOWN, 5'd5, 1'b0);
    queue_scan(16'd119, DIR_LEFT, 5'd3, 1'b0);
    queue_scan(16'd119, DIR_UP, 5'd3, 1'b0);
    queue_scan(16'd119, DIR_RIGHT, 5'd3, 1'b0);
    queue_scan(16'd119, DIR_DOWN, 5'd3, 1'b0);
    queue_scan(16'd265, DIR_LEFT, 5'd4, 1'b0);
    queue_scan(16'd256, DIR_UP, 5'd17, 1'b0);
    queue_scan(16'hFFFF, DIR_DOWN, 5'd31, 1'b0);
    queue_scan(16'h5555, DIR_RIGHT, 5'd10, 1'b0);
    queue_scan(16'hAAAA, DIR_LEFT, 5'd21, 1'b0);
    add_random(30);
    wait_idle();

    // Largest grid with no idling: full runs around the centre cell, then a corner and random requests
    set_grid(9'd256, 9'd256);
    src_nogap = 1'b1;
    snk_nogap = 1'b1;
    queue_scan(16'd32896, DIR_LEFT, 5'd16, 1'b0);
    queue_scan(16'd32896, DIR_UP, 5'd16, 1'b0);
    queue_scan(16'd32896, DIR_RIGHT, 5'd16, 1'b0);
    queue_scan(16'd32896, DIR_DOWN, 5'd16, 1'b0);
    queue_scan(16'hFFFF, DIR_UP, 5'd16, 1'b0);
    add_random(40);
    wait_idle();

    // Zero and oversize dimensions, then single-column and single-row grids
    src_nogap = 1'b0;
    snk_nogap = 1'b0;
    set_grid(9'd0, 9'd0);
    add_random(15);
    wait_idle();
    set_grid(9'd511, 9'd300);
    add_random(25);
    wait_idle();
    set_grid(9'd1, 9'd256);
    add_random(25);
    wait_idle();
    set_grid(9'd256, 9'd1);
    add_random(25);
    wait_idle();

    // Small random grids
    repeat (5) begin
      set_grid(DIM_W'($urandom_range(1, 40)), DIM_W'($urandom_range(1, 40)));
      {src_nogap, snk_nogap} = 2'($urandom_range(0, 3));
      add_random(30);
      wait_idle();
    end

    repeat (100) @(posedge clk_i);
    $display("Sent %0d scan requests over %0d grid settings;", scans_sent, settings_cnt + 1);
    $display("checked %0d results, %0d of them empty scans.", results_seen, empties_seen);
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

[grid_front_cell_scan.f]
+incdir+rtl
rtl/gfcs_pkg.sv
rtl/gfcs_divider.sv
rtl/gfcs_out_reg.sv
rtl/grid_front_cell_scan.sv
tb/sv/tb_grid_front_cell_scan.sv
